// ----- design/cbdq_pkg.sv -----
// Shared types and constants for the circular buffer deque unit.
package cbdq_pkg;

	// Storage geometry.
	localparam int DEPTH      = 1024;
	localparam int DATA_WIDTH = 32;
	localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// Operation codes carried by an input beat.
	typedef enum logic [1:0] {
		KIND_PUSH_FRONT = 2'd0,
		KIND_POP_FRONT  = 2'd1,
		KIND_PUSH_BACK  = 2'd2,
		KIND_POP_BACK   = 2'd3
	} kind_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// Input beat payload.
	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] push_value;
	} item_t;

	// Result beat payload.
	typedef struct packed {
		status_t            status;
		logic signed [31:0] popped_value;
		logic               now_empty;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic exec;
		logic respond;
	} cbdq_cmd_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RESP = 1'b1
	} state_t;

endpackage

// ----- design/circular_buffer_deque_unit.sv -----
// Top level of the circular buffer deque unit: controller plus datapath.
// The result beat appears in the cycle after the input beat is accepted.
// A new beat is not accepted until the last one's result is shown; busy is high during the result cycle.
// A successful op takes one access on the single-port entry memory and one pointer move.
// Reset (arst_n low) empties the deque at once; memory contents are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle with done high.
module circular_buffer_deque_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cbdq_pkg::item_t   item,
	output logic              done,
	output cbdq_pkg::result_t result
);

	cbdq_pkg::cbdq_cmd_t cmd;

	// Sequencing of accept and result cycles.
	cbdq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Storage, pointers and result registers.
	cbdq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.result (result)
	);

endmodule

// ----- design/cbdq_ctrl.sv -----
// Controller state machine: accepts a beat and sequences its result cycle.
module cbdq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output cbdq_pkg::cbdq_cmd_t cmd
);

	cbdq_pkg::state_t state_q;
	cbdq_pkg::state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbdq_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and outputs.
	always_comb begin
		state_next  = state_q;
		busy        = 1'b0;
		done        = 1'b0;
		cmd.exec    = 1'b0;
		cmd.respond = 1'b0;
		case (state_q)
			cbdq_pkg::ST_IDLE: begin
				if (start) begin
					cmd.exec   = 1'b1;
					state_next = cbdq_pkg::ST_RESP;
				end
			end
			cbdq_pkg::ST_RESP: begin
				busy        = 1'b1;
				done        = 1'b1;
				cmd.respond = 1'b1;
				state_next  = cbdq_pkg::ST_IDLE;
			end
			default: begin
				state_next = cbdq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- design/cbdq_dp.sv -----
// Datapath: entry memory, front and back pointers, entry count and result registers.
module cbdq_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  cbdq_pkg::cbdq_cmd_t cmd,
	input  cbdq_pkg::item_t     item,
	output cbdq_pkg::result_t   result
);

	localparam logic [cbdq_pkg::PTR_W-1:0] PTR_LAST = cbdq_pkg::PTR_W'(cbdq_pkg::DEPTH - 1);
	localparam logic [cbdq_pkg::CNT_W-1:0] CNT_FULL = cbdq_pkg::CNT_W'(cbdq_pkg::DEPTH);

	logic [cbdq_pkg::DATA_WIDTH-1:0] mem [cbdq_pkg::DEPTH];

	logic [cbdq_pkg::PTR_W-1:0]      front_q, back_q;
	logic [cbdq_pkg::CNT_W-1:0]      count_q;
	logic [cbdq_pkg::DATA_WIDTH-1:0] rd_q;
	cbdq_pkg::status_t               status_q;
	logic                            pop_ok_q;
	logic                            empty_q;

	logic [cbdq_pkg::PTR_W-1:0]      front_inc, front_dec, back_inc, back_dec;
	logic [cbdq_pkg::PTR_W-1:0]      front_next, back_next, waddr, raddr;
	logic [cbdq_pkg::CNT_W-1:0]      count_next;
	logic                            wr_en, rd_en, is_full, no_entries;
	cbdq_pkg::status_t               status_next;
	logic [63:0]                     push_ext, rd_ext;
	logic [cbdq_pkg::DATA_WIDTH-1:0] wdata;

	// Ring pointer neighbors with wrap in both directions.
	assign front_inc = (front_q == PTR_LAST) ? '0 : front_q + 1'b1;
	assign front_dec = (front_q == '0) ? PTR_LAST : front_q - 1'b1;
	assign back_inc  = (back_q == PTR_LAST) ? '0 : back_q + 1'b1;
	assign back_dec  = (back_q == '0) ? PTR_LAST : back_q - 1'b1;

	assign is_full    = (count_q == CNT_FULL);
	assign no_entries = (count_q == '0);

	// Only the low DATA_WIDTH bits of a pushed value are kept.
	assign push_ext = {32'b0, item.push_value};
	assign wdata    = push_ext[cbdq_pkg::DATA_WIDTH-1:0];

	// Decode the operation into memory accesses and the next pointer state.
	always_comb begin
		front_next  = front_q;
		back_next   = back_q;
		count_next  = count_q;
		wr_en       = 1'b0;
		rd_en       = 1'b0;
		waddr       = front_q;
		raddr       = front_inc;
		status_next = cbdq_pkg::STATUS_OK;
		case (item.kind)
			cbdq_pkg::KIND_PUSH_FRONT: begin
				if (is_full) begin
					status_next = cbdq_pkg::STATUS_FULL;
				end else begin
					wr_en      = 1'b1;
					waddr      = front_q;
					front_next = front_dec;
					count_next = count_q + 1'b1;
				end
			end
			cbdq_pkg::KIND_POP_FRONT: begin
				if (no_entries) begin
					status_next = cbdq_pkg::STATUS_EMPTY;
				end else begin
					rd_en      = 1'b1;
					raddr      = front_inc;
					front_next = front_inc;
					count_next = count_q - 1'b1;
				end
			end
			cbdq_pkg::KIND_PUSH_BACK: begin
				if (is_full) begin
					status_next = cbdq_pkg::STATUS_FULL;
				end else begin
					wr_en      = 1'b1;
					waddr      = back_q;
					back_next  = back_inc;
					count_next = count_q + 1'b1;
				end
			end
			cbdq_pkg::KIND_POP_BACK: begin
				if (no_entries) begin
					status_next = cbdq_pkg::STATUS_EMPTY;
				end else begin
					rd_en      = 1'b1;
					raddr      = back_dec;
					back_next  = back_dec;
					count_next = count_q - 1'b1;
				end
			end
			default: begin
				status_next = cbdq_pkg::STATUS_OK;
			end
		endcase
	end

	// Entry memory with a registered read port.
	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem[waddr] <= wdata;
		end
		if (cmd.exec && rd_en) begin
			rd_q <= mem[raddr];
		end
	end

	// Pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= PTR_LAST;
			back_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			front_q <= front_next;
			back_q  <= back_next;
			count_q <= count_next;
		end
	end

	// Result fields held for the response cycle.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_next;
			pop_ok_q <= rd_en;
			empty_q  <= (count_next == '0);
		end
	end

	// Drive the result only in the response cycle; a failed pop or a push reads as zero.
	assign rd_ext              = {{(64 - cbdq_pkg::DATA_WIDTH){1'b0}}, rd_q};
	assign result.status       = cmd.respond ? status_q : cbdq_pkg::STATUS_OK;
	assign result.popped_value = (cmd.respond && pop_ok_q) ? rd_ext[31:0] : '0;
	assign result.now_empty    = cmd.respond ? empty_q : 1'b0;

endmodule

// ----- verif/tb.sv -----
// Testbench for the circular buffer deque unit: directed, fill/drain and random op checks.
`timescale 1ns / 100ps

module tb;

	localparam int STALL_LIMIT = 1000;
	localparam int MAX_REPORTS = 10;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	cbdq_pkg::item_t   item;
	logic              done;
	cbdq_pkg::result_t result;

	// Deque shadow state kept by the predictor.
	logic [cbdq_pkg::DATA_WIDTH-1:0] shadow_ring [cbdq_pkg::DEPTH];
	logic [cbdq_pkg::PTR_W-1:0]      shadow_front;
	logic [cbdq_pkg::PTR_W-1:0]      shadow_back;
	logic [cbdq_pkg::CNT_W-1:0]      shadow_count;

	cbdq_pkg::result_t pending_results [$];
	cbdq_pkg::result_t oldest_expected;
	int                mismatch_count;
	int                stall_cycles;
	bit                sender_idles;

	circular_buffer_deque_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Applies one operation to the shadow deque and returns the result it should give.
	function automatic cbdq_pkg::result_t apply_deque_op(cbdq_pkg::item_t op_beat);
		cbdq_pkg::result_t res;
		res.status       = cbdq_pkg::STATUS_OK;
		res.popped_value = '0;
		if (op_beat.kind == cbdq_pkg::KIND_PUSH_FRONT ||
		    op_beat.kind == cbdq_pkg::KIND_PUSH_BACK) begin
			if (shadow_count == cbdq_pkg::CNT_W'(cbdq_pkg::DEPTH)) begin
				res.status = cbdq_pkg::STATUS_FULL;
			end else if (op_beat.kind == cbdq_pkg::KIND_PUSH_FRONT) begin
				shadow_ring[shadow_front] = op_beat.push_value[cbdq_pkg::DATA_WIDTH-1:0];
				shadow_front = (shadow_front == 0) ?
					cbdq_pkg::PTR_W'(cbdq_pkg::DEPTH - 1) : shadow_front - 1'b1;
				shadow_count++;
			end else begin
				shadow_ring[shadow_back] = op_beat.push_value[cbdq_pkg::DATA_WIDTH-1:0];
				shadow_back = (shadow_back == cbdq_pkg::PTR_W'(cbdq_pkg::DEPTH - 1)) ?
					'0 : shadow_back + 1'b1;
				shadow_count++;
			end
		end else begin
			if (shadow_count == 0) begin
				res.status = cbdq_pkg::STATUS_EMPTY;
			end else if (op_beat.kind == cbdq_pkg::KIND_POP_FRONT) begin
				shadow_front = (shadow_front == cbdq_pkg::PTR_W'(cbdq_pkg::DEPTH - 1)) ?
					'0 : shadow_front + 1'b1;
				res.popped_value = shadow_ring[shadow_front];
				shadow_count--;
			end else begin
				shadow_back = (shadow_back == 0) ?
					cbdq_pkg::PTR_W'(cbdq_pkg::DEPTH - 1) : shadow_back - 1'b1;
				res.popped_value = shadow_ring[shadow_back];
				shadow_count--;
			end
		end
		res.now_empty = (shadow_count == 0);
		return res;
	endfunction

	task automatic report_mismatch(string what, cbdq_pkg::result_t want,
		cbdq_pkg::result_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("%0t: %s: expected status=%0d popped=%0d empty=%0b,",
				$realtime, what, want.status, want.popped_value, want.now_empty);
			$display("    got status=%0d popped=%0d empty=%0b",
				got.status, got.popped_value, got.now_empty);
		end
	endtask

	// Result checking, then prediction for the beat accepted at this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result beat with nothing pending", '0, result);
				end else begin
					oldest_expected = pending_results[0];
					pending_results.delete(0);
					if (result.status !== oldest_expected.status ||
					    result.popped_value !== oldest_expected.popped_value ||
					    result.now_empty !== oldest_expected.now_empty) begin
						report_mismatch("result mismatch", oldest_expected, result);
					end
				end
			end
			if (start && !busy) begin
				pending_results.insert(pending_results.size(), apply_deque_op(item));
			end
		end
	end

	// Watchdog: ends the run when neither side moves a beat for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("SCOREBOARD MISMATCH");
					$finish;
				end
			end
		end
	end

	// Sends one operation; returns at a falling edge with start still high.
	task automatic send_op(cbdq_pkg::kind_t op, logic signed [31:0] value);
		int gap;
		gap = 0;
		if (sender_idles && $urandom_range(99) < 6) begin
			gap = $urandom_range(3, 1);
		end
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		item  <= '{kind: op, push_value: value};
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	// Holds the sender off until every pending result has come back.
	task automatic wait_results_drained();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		@(negedge clk);
	endtask

	// Push values lean toward the extremes now and then.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(7))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return -32'sd1;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic cbdq_pkg::kind_t pick_op(int push_pct);
		if ($urandom_range(99) < push_pct) begin
			if ($urandom_range(1) != 0) begin
				return cbdq_pkg::KIND_PUSH_FRONT;
			end
			return cbdq_pkg::KIND_PUSH_BACK;
		end
		if ($urandom_range(1) != 0) begin
			return cbdq_pkg::KIND_POP_FRONT;
		end
		return cbdq_pkg::KIND_POP_BACK;
	endfunction

	// Empty pops, pointer wrap at both ends and extreme values.
	task automatic test_directed();
		send_op(cbdq_pkg::KIND_POP_FRONT, 32'sh1234_5678);
		send_op(cbdq_pkg::KIND_POP_BACK, -32'sd1);
		send_op(cbdq_pkg::KIND_PUSH_FRONT, 32'sh8000_0000);
		send_op(cbdq_pkg::KIND_POP_BACK, '0);
		send_op(cbdq_pkg::KIND_PUSH_BACK, 32'sh7FFF_FFFF);
		send_op(cbdq_pkg::KIND_POP_FRONT, '0);
		send_op(cbdq_pkg::KIND_PUSH_FRONT, -32'sd1);
		send_op(cbdq_pkg::KIND_PUSH_BACK, '0);
		send_op(cbdq_pkg::KIND_PUSH_BACK, 32'sh5555_5555);
		send_op(cbdq_pkg::KIND_PUSH_FRONT, 32'shAAAA_AAAA);
		send_op(cbdq_pkg::KIND_POP_FRONT, '0);
		send_op(cbdq_pkg::KIND_POP_BACK, '0);
		send_op(cbdq_pkg::KIND_POP_BACK, '0);
		send_op(cbdq_pkg::KIND_POP_FRONT, '0);
		send_op(cbdq_pkg::KIND_POP_FRONT, '0);
		send_op(cbdq_pkg::KIND_POP_BACK, '0);
	endtask

	// Fills the deque completely, works around the full mark, then drains it.
	task automatic test_fill_drain();
		for (int n = 0; n < cbdq_pkg::DEPTH; n++) begin
			send_op(pick_op(100), pick_value());
		end
		send_op(cbdq_pkg::KIND_PUSH_FRONT, pick_value());
		send_op(cbdq_pkg::KIND_PUSH_BACK, pick_value());
		for (int n = 0; n < 60; n++) begin
			send_op(pick_op(70), pick_value());
		end
		while (shadow_count != 0) begin
			send_op(pick_op(0), pick_value());
		end
		send_op(cbdq_pkg::KIND_POP_FRONT, pick_value());
		send_op(cbdq_pkg::KIND_POP_BACK, pick_value());
	endtask

	// Random operations in segments that lean toward pushes, lean toward pops or are balanced.
	task automatic test_random_mix();
		int push_pct;
		for (int seg = 0; seg < 14; seg++) begin
			case ($urandom_range(2))
				0: push_pct = 15;
				1: push_pct = 50;
				default: push_pct = 85;
			endcase
			for (int n = 0; n < 50; n++) begin
				send_op(pick_op(push_pct), pick_value());
			end
			if (seg == 6) begin
				wait_results_drained();
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		item           = '0;
		mismatch_count = 0;
		stall_cycles   = 0;
		sender_idles   = 1'b1;
		shadow_front   = cbdq_pkg::PTR_W'(cbdq_pkg::DEPTH - 1);
		shadow_back    = '0;
		shadow_count   = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		wait_results_drained();
		sender_idles = 1'b0;
		test_fill_drain();
		wait_results_drained();
		sender_idles = 1'b1;
		test_random_mix();

		// Let the last result come back before judging the run.
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/cbdq_pkg.sv
design/cbdq_ctrl.sv
design/cbdq_dp.sv
design/circular_buffer_deque_unit.sv
verif/tb.sv
